[sv/bkl_pkg.sv]
// Package for the bakery lock arbiter: sizes, request kind codes, controller
// states and the command and status structs between controller and datapath.
// Depends on nothing.
package bkl_pkg;

    localparam int CPU_SLOTS = 8;
    localparam int SLOT_W    = (CPU_SLOTS > 2) ? $clog2(CPU_SLOTS) : 1;
    localparam int CMP_W     = (SLOT_W > 3) ? SLOT_W : 3;
    localparam int TICKET_W  = 32;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CPU_SLOTS - 1);

    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              commit;
    } bkl_cmd_t;

    typedef struct packed {
        logic out_free;
    } bkl_stat_t;

endpackage

[sv/bkl_ctrl.sv]
// Controller of the bakery lock arbiter: accepts a request, steps the scan
// over the ticket table and commits the result.
// Depends on bkl_pkg.
module bkl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bkl_pkg::bkl_stat_t  stat,
    output bkl_pkg::bkl_cmd_t   cmd
);

    bkl_pkg::state_t                  state_reg, state_next;
    logic [bkl_pkg::SLOT_W-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bkl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            bkl_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = bkl_pkg::ST_SCAN;
                end
            end
            bkl_pkg::ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bkl_pkg::LAST_SLOT) begin
                    state_next = bkl_pkg::ST_DRAIN;
                end
            end
            bkl_pkg::ST_DRAIN: begin
                state_next = bkl_pkg::ST_FINISH;
            end
            bkl_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = bkl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bkl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.rd_addr = cnt_reg;
        cmd.commit  = 1'b0;
        case (state_reg)
            bkl_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            bkl_pkg::ST_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            bkl_pkg::ST_DRAIN: begin
            end
            bkl_pkg::ST_FINISH: begin
                cmd.commit = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/bkl_datapath.sv]
// Datapath of the bakery lock arbiter: ticket memory with valid bits, scan
// accumulators, update logic and the result register.
// Depends on bkl_pkg.
module bkl_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [1:0]                      s_kind,
    input  logic [2:0]                      s_cpu_slot,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_granted,
    output logic [bkl_pkg::TICKET_W-1:0]    m_slot_ticket,
    output logic                            m_owner_valid,
    output logic [2:0]                      m_owner_slot,
    input  bkl_pkg::bkl_cmd_t               cmd,
    output bkl_pkg::bkl_stat_t              stat
);

    localparam int SW = bkl_pkg::SLOT_W;
    localparam int CW = bkl_pkg::CMP_W;
    localparam int TW = bkl_pkg::TICKET_W;

    logic [TW-1:0]                  ticket_mem [bkl_pkg::CPU_SLOTS];
    logic [bkl_pkg::CPU_SLOTS-1:0]  valid_reg;

    logic [1:0]     kind_reg;
    logic [2:0]     slot_reg;
    logic           slot_ok_reg;

    logic [TW-1:0]  rd_data_reg;
    logic           rd_ok_reg;
    logic [SW-1:0]  rd_idx_reg;
    logic           rd_valid_reg;

    logic [TW-1:0]  max_reg, max_next;
    logic [TW-1:0]  best_reg, best_next;
    logic [SW-1:0]  best_idx_reg, best_idx_next;
    logic           found_reg, found_next;
    logic [TW-1:0]  own_reg, own_next;

    logic           out_valid_reg;
    logic           granted_reg;
    logic [TW-1:0]  ticket_reg;
    logic           owner_valid_reg;
    logic [2:0]     owner_slot_reg;

    logic [TW-1:0]  rd_ticket;
    logic [TW-1:0]  new_ticket;
    logic           is_clear;
    logic           acq_new;
    logic           rel_own;
    logic [TW-1:0]  mine;
    logic           found_eff;
    logic           mine_wins;
    logic [SW-1:0]  wr_addr;

    assign stat.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg    <= s_kind;
            slot_reg    <= s_cpu_slot;
            slot_ok_reg <= ({29'b0, s_cpu_slot} < 32'(bkl_pkg::CPU_SLOTS));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= ticket_mem[cmd.rd_addr];
            rd_ok_reg   <= valid_reg[cmd.rd_addr];
            rd_idx_reg  <= cmd.rd_addr;
        end
        if (cmd.commit && acq_new) begin
            ticket_mem[wr_addr] <= new_ticket;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.commit) begin
                if (is_clear) begin
                    valid_reg <= '0;
                end else if (acq_new) begin
                    valid_reg[wr_addr] <= 1'b1;
                end else if (rel_own) begin
                    valid_reg[wr_addr] <= 1'b0;
                end
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rd_ticket = rd_ok_reg ? rd_data_reg : '0;

    always_comb begin
        max_next      = max_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        own_next      = own_reg;
        if (cmd.capture) begin
            max_next      = '0;
            best_next     = '0;
            best_idx_next = '0;
            found_next    = 1'b0;
            own_next      = '0;
        end else if (rd_valid_reg) begin
            if (slot_ok_reg && (CW'(rd_idx_reg) == CW'(slot_reg))) begin
                own_next = rd_ticket;
            end else begin
                if (rd_ticket > max_reg) begin
                    max_next = rd_ticket;
                end
                if ((rd_ticket != '0) && (!found_reg || (rd_ticket < best_reg))) begin
                    found_next    = 1'b1;
                    best_next     = rd_ticket;
                    best_idx_next = rd_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        max_reg      <= max_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        found_reg    <= found_next;
        own_reg      <= own_next;
    end

    always_comb begin
        new_ticket = (max_reg == {TW{1'b1}}) ? TW'(1) : (max_reg + TW'(1));
        is_clear   = (kind_reg == bkl_pkg::KIND_CLEAR);
        acq_new    = (kind_reg == bkl_pkg::KIND_ACQUIRE) && slot_ok_reg && (own_reg == '0);
        rel_own    = (kind_reg == bkl_pkg::KIND_RELEASE) && slot_ok_reg;
        wr_addr    = SW'(slot_reg);
        if (is_clear || rel_own) begin
            mine = '0;
        end else if (acq_new) begin
            mine = new_ticket;
        end else begin
            mine = own_reg;
        end
        found_eff = found_reg && !is_clear;
        mine_wins = (mine != '0) && (!found_eff || (mine < best_reg) ||
                    ((mine == best_reg) && (CW'(slot_reg) < CW'(best_idx_reg))));
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            granted_reg     <= mine_wins;
            ticket_reg      <= mine;
            owner_valid_reg <= found_eff || (mine != '0);
            if (mine_wins) begin
                owner_slot_reg <= slot_reg;
            end else if (found_eff) begin
                owner_slot_reg <= 3'(CW'(best_idx_reg));
            end else begin
                owner_slot_reg <= 3'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_granted     = granted_reg;
    assign m_slot_ticket = ticket_reg;
    assign m_owner_valid = owner_valid_reg;
    assign m_owner_slot  = owner_slot_reg;

endmodule

[sv/bakery_lock_arbiter_core.sv]
// Bakery lock arbiter: one request in, one result out. After the request
// transfer the controller scans the ticket memory one slot per cycle through
// its single read port, drains the last read and commits the result, and it
// takes no new request before that commit; the result register lets the next
// request start while a result waits, and that request then holds in its last
// cycle until the result is taken.
// Clearing all tickets takes effect at once through valid bits.
// Depends on bkl_pkg, bkl_ctrl and bkl_datapath.
module bakery_lock_arbiter_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_kind,
    input  logic [2:0]   s_cpu_slot,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_granted,
    output logic [31:0]  m_slot_ticket,
    output logic         m_owner_valid,
    output logic [2:0]   m_owner_slot
);

    bkl_pkg::bkl_cmd_t  cmd;
    bkl_pkg::bkl_stat_t stat;

    bkl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bkl_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_cpu_slot    (s_cpu_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_slot_ticket (m_slot_ticket),
        .m_owner_valid (m_owner_valid),
        .m_owner_slot  (m_owner_slot),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[sv/bkl_checker.sv]
// Port-level checker for the bakery lock arbiter, bound to the top level.
// Depends on bakery_lock_arbiter_core.
module bkl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_valid,
    input logic         m_ready,
    input logic         m_granted,
    input logic [31:0]  m_slot_ticket,
    input logic         m_owner_valid,
    input logic [2:0]   m_owner_slot
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot_ticket) && $stable(m_granted))
        else $error("Result changed while stalled.");

    a_granted_has_ticket: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_owner_valid && (m_slot_ticket != 32'd0))
        else $error("Grant without a ticket or owner.");

    a_no_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_owner_valid |-> (m_owner_slot == 3'd0) && !m_granted
            && (m_slot_ticket == 32'd0))
        else $error("Owner fields inconsistent with an empty table.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid straight after reset.");

endmodule

bind bakery_lock_arbiter_core bkl_checker u_bkl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_granted     (m_granted),
    .m_slot_ticket (m_slot_ticket),
    .m_owner_valid (m_owner_valid),
    .m_owner_slot  (m_owner_slot)
);

[bench/testbench.sv]
// Self-checking bench for bakery_lock_arbiter_core. A queue-fed driver, a stalling receiver
// and a ticket-table predictor check every result in order.
// Depends on bkl_pkg and the arbiter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [1:0] kind;
        logic [2:0] slot;
        bit         hold;
    } lock_req_t;

    typedef struct packed {
        logic                         granted;
        logic [bkl_pkg::TICKET_W-1:0] ticket;
        logic                         owner_valid;
        logic [2:0]                   owner_slot;
    } lock_status_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind     = bkl_pkg::KIND_QUERY;
    logic [2:0]  s_cpu_slot = '0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic        m_granted;
    logic [31:0] m_slot_ticket;
    logic        m_owner_valid;
    logic [2:0]  m_owner_slot;

    lock_req_t                    pending_q[$];
    lock_status_t                 lock_status_q[$];
    logic [bkl_pkg::TICKET_W-1:0] ticket_book [bkl_pkg::CPU_SLOTS] = '{default: '0};

    int unsigned issued_cnt = 0;
    int unsigned taken_cnt  = 0;
    int unsigned err_cnt    = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned rdy_mode   = 0;
    int unsigned mode_left  = 0;

    bakery_lock_arbiter_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_cpu_slot    (s_cpu_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_slot_ticket (m_slot_ticket),
        .m_owner_valid (m_owner_valid),
        .m_owner_slot  (m_owner_slot)
    );

    always #5 aclk = ~aclk;

    function automatic lock_status_t bakery_step(input logic [1:0] kind,
                                                 input logic [2:0] slot);
        lock_status_t                 res;
        logic [bkl_pkg::TICKET_W-1:0] top;
        logic [bkl_pkg::TICKET_W-1:0] best;
        bit                           found;
        res   = '0;
        top   = '0;
        best  = '0;
        found = 1'b0;
        if (kind == bkl_pkg::KIND_CLEAR) begin
            foreach (ticket_book[i]) ticket_book[i] = '0;
        end else if (kind == bkl_pkg::KIND_ACQUIRE && ticket_book[slot] == '0) begin
            foreach (ticket_book[i]) begin
                if (ticket_book[i] > top) top = ticket_book[i];
            end
            top = top + 1'b1;
            ticket_book[slot] = (top == '0) ? bkl_pkg::TICKET_W'(1) : top;
        end else if (kind == bkl_pkg::KIND_RELEASE) begin
            ticket_book[slot] = '0;
        end
        foreach (ticket_book[i]) begin
            if (ticket_book[i] != '0 && (!found || ticket_book[i] < best)) begin
                found          = 1'b1;
                best           = ticket_book[i];
                res.owner_slot = 3'(i);
            end
        end
        res.owner_valid = found;
        res.ticket      = ticket_book[slot];
        res.granted     = found && ticket_book[slot] != '0 && res.owner_slot == slot;
        return res;
    endfunction

    function automatic void add_req(input logic [1:0] kind, input logic [2:0] slot,
                                    input bit hold = 1'b0);
        lock_req_t req;
        req.kind = kind;
        req.slot = slot;
        req.hold = hold;
        pending_q.push_back(req);
    endfunction

    always @(negedge aclk) begin : feed_requests
        lock_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && taken_cnt != issued_cnt)) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         (!pending_q[0].hold || lock_status_q.size() == 0)) begin
                req = pending_q.pop_front();
                s_kind     <= req.kind;
                s_cpu_slot <= req.slot;
                s_valid    <= 1'b1;
                issued_cnt = issued_cnt + 1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_ready
        if (mode_left == 0) begin
            rdy_mode  = $urandom_range(0, 2);
            mode_left = $urandom_range(64, 256);
        end else begin
            mode_left = mode_left - 1;
        end
        case (rdy_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin : check_results
        lock_status_t exp_st;
        lock_status_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_granted, m_slot_ticket, m_owner_valid, m_owner_slot};
                if (lock_status_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10) begin
                        $display("Unexpected result: granted=%0d ticket=%0d owner=%0d/%0d",
                                 got.granted, got.ticket, got.owner_valid, got.owner_slot);
                    end
                end else begin
                    exp_st = lock_status_q.pop_front();
                    if (got !== exp_st) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display({"Mismatch (expected/actual): granted %0d/%0d ",
                                      "ticket %0d/%0d owner_valid %0d/%0d ",
                                      "owner_slot %0d/%0d"},
                                     exp_st.granted, got.granted, exp_st.ticket, got.ticket,
                                     exp_st.owner_valid, got.owner_valid,
                                     exp_st.owner_slot, got.owner_slot);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                lock_status_q.push_back(bakery_step(s_kind, s_cpu_slot));
                taken_cnt = taken_cnt + 1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : run_stimulus
        int unsigned dir_cnt;
        int unsigned r;
        logic [2:0]  sl;
        // The table starts empty, so the first two requests see no owner at all.
        add_req(bkl_pkg::KIND_QUERY, 3'd0);
        add_req(bkl_pkg::KIND_RELEASE, 3'd2);
        add_req(bkl_pkg::KIND_ACQUIRE, 3'd0);
        add_req(bkl_pkg::KIND_ACQUIRE, 3'd0);
        add_req(bkl_pkg::KIND_ACQUIRE, 3'd7);
        add_req(bkl_pkg::KIND_QUERY, 3'd7);
        add_req(bkl_pkg::KIND_ACQUIRE, 3'd3);
        add_req(bkl_pkg::KIND_RELEASE, 3'd0);
        add_req(bkl_pkg::KIND_RELEASE, 3'd0);
        add_req(bkl_pkg::KIND_QUERY, 3'd3);
        add_req(bkl_pkg::KIND_QUERY, 3'd0);
        add_req(bkl_pkg::KIND_ACQUIRE, 3'd0);
        add_req(bkl_pkg::KIND_RELEASE, 3'd7);
        add_req(bkl_pkg::KIND_RELEASE, 3'd3);
        add_req(bkl_pkg::KIND_CLEAR, 3'd5, 1'b1);
        add_req(bkl_pkg::KIND_QUERY, 3'd5);
        for (int i = 1; i < 8; i++) add_req(bkl_pkg::KIND_ACQUIRE, 3'(i));
        add_req(bkl_pkg::KIND_QUERY, 3'd4);
        add_req(bkl_pkg::KIND_CLEAR, 3'd7);
        dir_cnt = pending_q.size();

        // Mostly acquire, poll and release traffic, with the odd full clear.
        while (pending_q.size() < dir_cnt + RANDOM_ITEMS) begin
            r  = $urandom_range(0, 99);
            sl = 3'($urandom_range(0, 7));
            if (r < 35) begin
                add_req(bkl_pkg::KIND_ACQUIRE, sl, (pending_q.size() % 500) == 499);
            end else if (r < 55) begin
                add_req(bkl_pkg::KIND_RELEASE, sl);
            end else if (r < 90) begin
                add_req(bkl_pkg::KIND_QUERY, sl);
            end else if (r < 93) begin
                add_req(bkl_pkg::KIND_CLEAR, sl);
            end else begin
                add_req(bkl_pkg::KIND_ACQUIRE, sl);
                repeat ($urandom_range(1, 4)) add_req(bkl_pkg::KIND_QUERY, sl);
                add_req(bkl_pkg::KIND_RELEASE, sl);
            end
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || taken_cnt != issued_cnt || lock_status_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (err_cnt == 0 && lock_status_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[bakery_lock_arbiter_core.f]
sv/bkl_pkg.sv
sv/bkl_ctrl.sv
sv/bkl_datapath.sv
sv/bakery_lock_arbiter_core.sv
sv/bkl_checker.sv
bench/testbench.sv
